/* design/fswa_pkg.sv */
// Package: shared constants, register map and payload types of the frame analyzer.
package fswa_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int SIZE_W     = 12;
  localparam int PCT_W      = 7;
  localparam int LIM_W      = 10;
  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int TALLY_W    = 12;
  localparam int TOTAL_W    = 23;
  localparam int PADDR_W    = 5;

  // x / 100 as (x * PCT_RECIP) >> PCT_SHIFT, exact for x below 2^18
  localparam int PROD_W     = SIZE_W + PCT_W;
  localparam int RECIP_W    = 19;
  localparam logic [RECIP_W-1:0] PCT_RECIP = 19'd335545;
  localparam int PCT_SHIFT  = 25;

  typedef enum logic [PADDR_W-1:0] {
    REG_FRAME_WIDTH    = 5'd0,
    REG_FRAME_HEIGHT   = 5'd4,
    REG_WHITE_LEVEL    = 5'd8,
    REG_STRIPE_PERCENT = 5'd12,
    REG_MATCH_LIMIT    = 5'd16,
    REG_JUMP_LIMIT     = 5'd20
  } reg_addr_t;

  typedef struct packed {
    logic [ROW_W-1:0]   row_index;
    logic [TALLY_W-1:0] row_white_count;
    logic               row_is_stripe;
    logic               row_has_wrap;
    logic               frame_done;
    logic [TOTAL_W-1:0] total_white;
    logic [TALLY_W-1:0] stripe_row_count;
    logic [TALLY_W-1:0] stripe_columns;
    logic [TALLY_W-1:0] right_wrap_rows;
    logic [TALLY_W-1:0] top_wrap_columns;
  } report_t;

  function automatic logic [LIM_W-1:0] pixel_diff(input logic [PIX_W-1:0] p,
                                                  input logic [PIX_W-1:0] q);
    logic [LIM_W-1:0] sum;
    logic [CH_W-1:0]  a;
    logic [CH_W-1:0]  b;
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      a = p[i*CH_W +: CH_W];
      b = q[i*CH_W +: CH_W];
      sum = sum + LIM_W'((a > b) ? (a - b) : (b - a));
    end
    return sum;
  endfunction

endpackage

/* design/fswa_if.sv */
// Interfaces: pixel input channel and row report output channel.
interface fswa_pix_if import fswa_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

interface fswa_rpt_if import fswa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ROW_W-1:0]   row_index;
  logic [TALLY_W-1:0] row_white_count;
  logic               row_is_stripe;
  logic               row_has_wrap;
  logic               frame_done;
  logic [TOTAL_W-1:0] total_white;
  logic [TALLY_W-1:0] stripe_row_count;
  logic [TALLY_W-1:0] stripe_columns;
  logic [TALLY_W-1:0] right_wrap_rows;
  logic [TALLY_W-1:0] top_wrap_columns;
  modport source (output valid, row_index, row_white_count, row_is_stripe, row_has_wrap,
                  frame_done, total_white, stripe_row_count, stripe_columns, right_wrap_rows,
                  top_wrap_columns, input ready);
  modport sink (input valid, row_index, row_white_count, row_is_stripe, row_has_wrap,
                frame_done, total_white, stripe_row_count, stripe_columns, right_wrap_rows,
                top_wrap_columns, output ready);
endinterface

/* design/fswa_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module fswa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/frame_stripe_and_wrap_analyzer.sv */
// Top level: frame stripe and wrap analyzer with APB configuration.
//
//  channel | dir | beat                          | when
//  --------+-----+-------------------------------+-------------------------------
//  pix     | in  | one RGB pixel, raster order   | valid && ready
//  rpt     | out | one report per completed row  | valid && ready
//  apb     | in  | register write / read         | psel && penable && pwrite
//
//  One pixel per cycle sustained unless a register write or a waiting report
//  holds pix.ready low. A pixel passes the address stage (line store and
//  column tally reads issue), then the update stage: read data, modify, write back.
//  Reset clears positions, totals and registers; the line stores are not cleared.
//  A report waiting on rpt stalls the update stage only when it holds a row end.
//  Hold pix.ready low in the cycle after a register write so the stripe
//  thresholds, two registered steps behind the registers, settle first.
module frame_stripe_and_wrap_analyzer
  import fswa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  fswa_pix_if.sink           pix,
  fswa_rpt_if.source         rpt,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // ---------------------------------------------------------------- registers
  logic [SIZE_W-1:0] frame_width;
  logic [SIZE_W-1:0] frame_height;
  logic [CH_W-1:0]   white_level;
  logic [PCT_W-1:0]  stripe_percent;
  logic [LIM_W-1:0]  match_limit;
  logic [LIM_W-1:0]  jump_limit;
  logic              cfg_hold;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width    <= SIZE_W'(640);
      frame_height   <= SIZE_W'(480);
      white_level    <= CH_W'(250);
      stripe_percent <= PCT_W'(80);
      match_limit    <= LIM_W'(10);
      jump_limit     <= LIM_W'(50);
    end else if (psel && penable && pwrite) begin
      case (reg_addr_t'(paddr))
        REG_FRAME_WIDTH:    frame_width    <= pwdata[SIZE_W-1:0];
        REG_FRAME_HEIGHT:   frame_height   <= pwdata[SIZE_W-1:0];
        REG_WHITE_LEVEL:    white_level    <= pwdata[CH_W-1:0];
        REG_STRIPE_PERCENT: stripe_percent <= pwdata[PCT_W-1:0];
        REG_MATCH_LIMIT:    match_limit    <= pwdata[LIM_W-1:0];
        REG_JUMP_LIMIT:     jump_limit     <= pwdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold the input in the cycle after each write
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_hold <= 1'b0;
    end else begin
      cfg_hold <= psel && penable && pwrite;
    end
  end

  always_comb begin
    case (reg_addr_t'(paddr))
      REG_FRAME_WIDTH:    prdata = 32'(frame_width);
      REG_FRAME_HEIGHT:   prdata = 32'(frame_height);
      REG_WHITE_LEVEL:    prdata = 32'(white_level);
      REG_STRIPE_PERCENT: prdata = 32'(stripe_percent);
      REG_MATCH_LIMIT:    prdata = 32'(match_limit);
      REG_JUMP_LIMIT:     prdata = 32'(jump_limit);
      default:            prdata = '0;
    endcase
  end

  // Clamp sizes to 2..MAX
  logic [SIZE_W-1:0] width_c;
  logic [SIZE_W-1:0] height_c;

  always_comb begin
    if (frame_width < SIZE_W'(2))              width_c = SIZE_W'(2);
    else if (frame_width > SIZE_W'(MAX_WIDTH)) width_c = SIZE_W'(MAX_WIDTH);
    else                                       width_c = frame_width;
    if (frame_height < SIZE_W'(2))               height_c = SIZE_W'(2);
    else if (frame_height > SIZE_W'(MAX_HEIGHT)) height_c = SIZE_W'(MAX_HEIGHT);
    else                                         height_c = frame_height;
  end

  // Stripe thresholds: size * percent / 100, two registered multiply steps
  logic [PROD_W-1:0]          width_prod;
  logic [PROD_W-1:0]          height_prod;
  logic [PROD_W+RECIP_W-1:0]  width_scaled;
  logic [PROD_W+RECIP_W-1:0]  height_scaled;
  logic [TALLY_W-1:0]         width_limit;
  logic [TALLY_W-1:0]         height_limit;

  always_ff @(posedge clk) begin
    width_prod    <= PROD_W'(width_c) * PROD_W'(stripe_percent);
    height_prod   <= PROD_W'(height_c) * PROD_W'(stripe_percent);
  end

  assign width_scaled  = (PROD_W+RECIP_W)'(width_prod) * (PROD_W+RECIP_W)'(PCT_RECIP);
  assign height_scaled = (PROD_W+RECIP_W)'(height_prod) * (PROD_W+RECIP_W)'(PCT_RECIP);

  always_ff @(posedge clk) begin
    width_limit  <= width_scaled[PCT_SHIFT +: TALLY_W];
    height_limit <= height_scaled[PCT_SHIFT +: TALLY_W];
  end

  // ---------------------------------------------------------- address stage
  logic [COL_W-1:0] column_position;
  logic [ROW_W-1:0] row_position;
  logic             accept;
  logic             a_row_end;
  logic             a_last_row;
  logic             upd_advance;

  assign pix.ready  = upd_advance && !cfg_hold;
  assign accept     = pix.valid && upd_advance && !cfg_hold;
  assign a_row_end  = SIZE_W'(column_position) >= (width_c - SIZE_W'(1));
  assign a_last_row = SIZE_W'(row_position) >= (height_c - SIZE_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
      row_position    <= '0;
    end else if (accept) begin
      if (a_row_end) begin
        column_position <= '0;
        row_position    <= a_last_row ? '0 : row_position + ROW_W'(1);
      end else begin
        column_position <= column_position + COL_W'(1);
      end
    end
  end

  // ----------------------------------------------------------- update stage
  logic             upd_valid;
  logic [PIX_W-1:0] upd_px;
  logic [COL_W-1:0] upd_col;
  logic [ROW_W-1:0] upd_row;
  logic             upd_row_end;
  logic             upd_last_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      upd_valid <= 1'b0;
    end else if (upd_advance) begin
      upd_valid <= accept;
    end
    if (accept) begin
      upd_px       <= {pix.red, pix.green, pix.blue};
      upd_col      <= column_position;
      upd_row      <= row_position;
      upd_row_end  <= a_row_end;
      upd_last_row <= a_last_row;
    end
  end

  // Hold a row end while the previous report still waits
  assign upd_advance = !upd_valid || !upd_row_end || !rpt.valid || rpt.ready;

  logic done;
  assign done = upd_valid && upd_advance;

  // Line stores and column tallies; a column is revisited at least two pixels later
  logic [TALLY_W-1:0] col_tally_rd;
  logic [PIX_W-1:0]   top_rd;
  logic [PIX_W-1:0]   second_rd;
  logic [TALLY_W-1:0] col_tally_new;
  logic               upd_row0;
  logic               upd_row1;

  assign upd_row0 = upd_row == ROW_W'(0);
  assign upd_row1 = upd_row == ROW_W'(1);

  fswa_ram #(.WIDTH(TALLY_W), .DEPTH(MAX_WIDTH)) u_col_tally (
    .clk   (clk),
    .we    (done),
    .waddr (upd_col),
    .wdata (col_tally_new),
    .re    (accept),
    .raddr (column_position),
    .rdata (col_tally_rd)
  );

  fswa_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_top_row (
    .clk   (clk),
    .we    (done && upd_row0),
    .waddr (upd_col),
    .wdata (upd_px),
    .re    (accept),
    .raddr (column_position),
    .rdata (top_rd)
  );

  fswa_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_second_row (
    .clk   (clk),
    .we    (done && upd_row1),
    .waddr (upd_col),
    .wdata (upd_px),
    .re    (accept),
    .raddr (column_position),
    .rdata (second_rd)
  );

  logic white;
  assign white = (upd_px[2*CH_W +: CH_W] >= white_level) &&
                 (upd_px[CH_W +: CH_W] >= white_level) &&
                 (upd_px[0 +: CH_W] >= white_level);

  assign col_tally_new = upd_row0 ? TALLY_W'(white) : col_tally_rd + TALLY_W'(white);

  // Frame state
  logic [TALLY_W-1:0] row_white_tally;
  logic [PIX_W-1:0]   row_left_pixel;
  logic [PIX_W-1:0]   previous_pixel;
  logic [TOTAL_W-1:0] white_total;
  logic [TALLY_W-1:0] stripe_row_total;
  logic [TALLY_W-1:0] stripe_column_total;
  logic [TALLY_W-1:0] right_wrap_total;
  logic [TALLY_W-1:0] top_wrap_total;

  logic [TALLY_W-1:0] row_tally_next;
  logic [TOTAL_W-1:0] white_total_next;
  logic [TALLY_W-1:0] stripe_row_next;
  logic [TALLY_W-1:0] stripe_column_next;
  logic [TALLY_W-1:0] right_wrap_next;
  logic [TALLY_W-1:0] top_wrap_next;
  logic [PIX_W-1:0]   left_px;
  logic [PIX_W-1:0]   second_px;
  logic               row_stripe;
  logic               row_wrap;
  logic               col_stripe;
  logic               top_wrap;

  always_comb begin
    left_px   = (upd_col == COL_W'(0)) ? upd_px : row_left_pixel;
    second_px = upd_row1 ? upd_px : second_rd;

    row_tally_next   = row_white_tally + TALLY_W'(white);
    white_total_next = white_total + TOTAL_W'(white);

    row_stripe = row_tally_next > width_limit;
    row_wrap   = (pixel_diff(upd_px, left_px) < match_limit) &&
                 (pixel_diff(upd_px, previous_pixel) > jump_limit);
    col_stripe = upd_last_row && (col_tally_new > height_limit);
    top_wrap   = upd_last_row && (pixel_diff(top_rd, upd_px) < match_limit) &&
                 (pixel_diff(top_rd, second_px) > jump_limit);

    stripe_column_next = stripe_column_total + TALLY_W'(col_stripe);
    top_wrap_next      = top_wrap_total + TALLY_W'(top_wrap);
    stripe_row_next    = stripe_row_total + TALLY_W'(upd_row_end && row_stripe);
    right_wrap_next    = right_wrap_total + TALLY_W'(upd_row_end && row_wrap);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_white_tally     <= '0;
      row_left_pixel      <= '0;
      previous_pixel      <= '0;
      white_total         <= '0;
      stripe_row_total    <= '0;
      stripe_column_total <= '0;
      right_wrap_total    <= '0;
      top_wrap_total      <= '0;
    end else if (done) begin
      previous_pixel <= upd_px;
      if (upd_col == COL_W'(0)) begin
        row_left_pixel <= upd_px;
      end
      row_white_tally <= upd_row_end ? '0 : row_tally_next;
      if (upd_row_end && upd_last_row) begin
        // Frame ends: clear totals for the next frame
        white_total         <= '0;
        stripe_row_total    <= '0;
        stripe_column_total <= '0;
        right_wrap_total    <= '0;
        top_wrap_total      <= '0;
      end else begin
        white_total         <= white_total_next;
        stripe_row_total    <= stripe_row_next;
        stripe_column_total <= stripe_column_next;
        right_wrap_total    <= right_wrap_next;
        top_wrap_total      <= top_wrap_next;
      end
    end
  end

  // ---------------------------------------------------------- report output
  report_t rpt_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      rpt.valid <= 1'b0;
    end else if (done && upd_row_end) begin
      rpt.valid <= 1'b1;
    end else if (rpt.ready) begin
      rpt.valid <= 1'b0;
    end
    if (done && upd_row_end) begin
      rpt_q.row_index        <= upd_row;
      rpt_q.row_white_count  <= row_tally_next;
      rpt_q.row_is_stripe    <= row_stripe;
      rpt_q.row_has_wrap     <= row_wrap;
      rpt_q.frame_done       <= upd_last_row;
      rpt_q.total_white      <= white_total_next;
      rpt_q.stripe_row_count <= stripe_row_next;
      rpt_q.stripe_columns   <= stripe_column_next;
      rpt_q.right_wrap_rows  <= right_wrap_next;
      rpt_q.top_wrap_columns <= top_wrap_next;
    end
  end

  assign rpt.row_index        = rpt_q.row_index;
  assign rpt.row_white_count  = rpt_q.row_white_count;
  assign rpt.row_is_stripe    = rpt_q.row_is_stripe;
  assign rpt.row_has_wrap     = rpt_q.row_has_wrap;
  assign rpt.frame_done       = rpt_q.frame_done;
  assign rpt.total_white      = rpt_q.total_white;
  assign rpt.stripe_row_count = rpt_q.stripe_row_count;
  assign rpt.stripe_columns   = rpt_q.stripe_columns;
  assign rpt.right_wrap_rows  = rpt_q.right_wrap_rows;
  assign rpt.top_wrap_columns = rpt_q.top_wrap_columns;

endmodule

/* tb/tb_frame_stripe_and_wrap_analyzer.sv */
// Testbench: raster pixel stimulus with row report checking for the frame analyzer.
`timescale 1ns / 1ps

module tb_frame_stripe_and_wrap_analyzer;
  import fswa_pkg::*;

  localparam int STALL_LIMIT = 5000;  // cycles with no beat before giving up
  localparam int HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int RANDOM_PIXELS = 1500;

  // Mirror of the analyzer: registers, positions, line stores and frame totals.
  // Each accepted pixel advances it; a row end queues the report it predicts.
  class frame_scoreboard;
    logic [SIZE_W-1:0] width_reg, height_reg;
    logic [CH_W-1:0]   white_reg;
    logic [PCT_W-1:0]  pct_reg;
    logic [LIM_W-1:0]  match_reg, jump_reg;
    int                col_pos, row_pos, row_tally;
    int                col_tally[MAX_WIDTH];
    logic [PIX_W-1:0]  top_line[MAX_WIDTH];
    logic [PIX_W-1:0]  second_line[MAX_WIDTH];
    logic [PIX_W-1:0]  left_px, prev_px;
    int                white_sum, stripe_row_sum, stripe_col_sum;
    int                right_wrap_sum, top_wrap_sum;
    report_t           expected_reports[$];

    function new();
      width_reg = 640; height_reg = 480; white_reg = 250; pct_reg = 80;
      match_reg = 10; jump_reg = 50;
      col_pos = 0; row_pos = 0; row_tally = 0;
      left_px = '0; prev_px = '0;
      white_sum = 0; stripe_row_sum = 0; stripe_col_sum = 0;
      right_wrap_sum = 0; top_wrap_sum = 0;
    endfunction

    function void set_register(reg_addr_t addr, logic [31:0] value);
      case (addr)
        REG_FRAME_WIDTH:    width_reg  = value[SIZE_W-1:0];
        REG_FRAME_HEIGHT:   height_reg = value[SIZE_W-1:0];
        REG_WHITE_LEVEL:    white_reg  = value[CH_W-1:0];
        REG_STRIPE_PERCENT: pct_reg    = value[PCT_W-1:0];
        REG_MATCH_LIMIT:    match_reg  = value[LIM_W-1:0];
        REG_JUMP_LIMIT:     jump_reg   = value[LIM_W-1:0];
        default: ;
      endcase
    endfunction

    function int clamp_size(int v, int hi);
      if (v < 2) return 2;
      if (v > hi) return hi;
      return v;
    endfunction

    function int rgb_distance(logic [PIX_W-1:0] p, logic [PIX_W-1:0] q);
      int sum;
      int a;
      int b;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        a = p[i*CH_W +: CH_W];
        b = q[i*CH_W +: CH_W];
        sum += (a > b) ? a - b : b - a;
      end
      return sum;
    endfunction

    function void note_pixel(logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b);
      int               w;
      int               h;
      int               col;
      int               row;
      logic [PIX_W-1:0] px;
      bit               white;
      bit               last;
      bit               wrap;
      bit               stripe;
      logic [PIX_W-1:0] top;
      report_t          rep;
      w = clamp_size(width_reg, MAX_WIDTH);
      h = clamp_size(height_reg, MAX_HEIGHT);
      col = col_pos % MAX_WIDTH;
      row = row_pos;
      px = {r, g, b};
      white = (r >= white_reg) && (g >= white_reg) && (b >= white_reg);
      last = row >= h - 1;
      row_tally += white;
      white_sum += white;
      if (row == 0) begin
        col_tally[col] = white;
        top_line[col] = px;
      end else begin
        col_tally[col] += white;
      end
      if (row == 1) second_line[col] = px;
      if (last) begin
        top = top_line[col];
        if (col_tally[col] > h * int'(pct_reg) / 100) stripe_col_sum++;
        if (rgb_distance(top, px) < match_reg && rgb_distance(top, second_line[col]) > jump_reg)
          top_wrap_sum++;
      end
      if (col == 0) left_px = px;
      if (col >= w - 1) begin
        wrap = rgb_distance(px, left_px) < match_reg && rgb_distance(px, prev_px) > jump_reg;
        stripe = row_tally > w * int'(pct_reg) / 100;
        right_wrap_sum += wrap;
        stripe_row_sum += stripe;
        rep.row_index        = ROW_W'(row);
        rep.row_white_count  = TALLY_W'(row_tally);
        rep.row_is_stripe    = stripe;
        rep.row_has_wrap     = wrap;
        rep.frame_done       = last;
        rep.total_white      = TOTAL_W'(white_sum);
        rep.stripe_row_count = TALLY_W'(stripe_row_sum);
        rep.stripe_columns   = TALLY_W'(stripe_col_sum);
        rep.right_wrap_rows  = TALLY_W'(right_wrap_sum);
        rep.top_wrap_columns = TALLY_W'(top_wrap_sum);
        expected_reports.push_back(rep);
        row_tally = 0;
        col_pos = 0;
        prev_px = px;
        if (last) begin
          row_pos = 0; white_sum = 0; stripe_row_sum = 0; stripe_col_sum = 0;
          right_wrap_sum = 0; top_wrap_sum = 0;
        end else begin
          row_pos = row + 1;
        end
      end else begin
        prev_px = px;
        col_pos = col + 1;
      end
    endfunction

    // Empty string when the report agrees with the oldest prediction.
    function string check_report(report_t got);
      report_t exp;
      string   msg;
      if (expected_reports.size() == 0) return "report with no prediction waiting";
      exp = expected_reports.pop_front();
      msg = "";
      if (got.row_index !== exp.row_index)
        msg = {msg, $sformatf(" row_index %0d/%0d", got.row_index, exp.row_index)};
      if (got.row_white_count !== exp.row_white_count)
        msg = {msg, $sformatf(" row_white_count %0d/%0d", got.row_white_count,
                              exp.row_white_count)};
      if (got.row_is_stripe !== exp.row_is_stripe)
        msg = {msg, $sformatf(" row_is_stripe %0d/%0d", got.row_is_stripe, exp.row_is_stripe)};
      if (got.row_has_wrap !== exp.row_has_wrap)
        msg = {msg, $sformatf(" row_has_wrap %0d/%0d", got.row_has_wrap, exp.row_has_wrap)};
      if (got.frame_done !== exp.frame_done)
        msg = {msg, $sformatf(" frame_done %0d/%0d", got.frame_done, exp.frame_done)};
      if (got.total_white !== exp.total_white)
        msg = {msg, $sformatf(" total_white %0d/%0d", got.total_white, exp.total_white)};
      if (got.stripe_row_count !== exp.stripe_row_count)
        msg = {msg, $sformatf(" stripe_row_count %0d/%0d", got.stripe_row_count,
                              exp.stripe_row_count)};
      if (got.stripe_columns !== exp.stripe_columns)
        msg = {msg, $sformatf(" stripe_columns %0d/%0d", got.stripe_columns,
                              exp.stripe_columns)};
      if (got.right_wrap_rows !== exp.right_wrap_rows)
        msg = {msg, $sformatf(" right_wrap_rows %0d/%0d", got.right_wrap_rows,
                              exp.right_wrap_rows)};
      if (got.top_wrap_columns !== exp.top_wrap_columns)
        msg = {msg, $sformatf(" top_wrap_columns %0d/%0d", got.top_wrap_columns,
                              exp.top_wrap_columns)};
      if (msg != "") msg = {$sformatf("row %0d mismatch (got/exp):", exp.row_index), msg};
      return msg;
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  fswa_pix_if pix_if ();
  fswa_rpt_if rpt_if ();

  frame_scoreboard  sb;
  int               mismatches;
  int               send_idle_pct;
  int               recv_stall_pct;
  int               hold_requests;
  int               hold_served;
  int               hold_left;
  int               quiet_cycles;
  int               pixels_sent;
  logic [PIX_W-1:0] gen_top[MAX_WIDTH];
  report_t          got_report;
  string            mismatch_msg;

  frame_stripe_and_wrap_analyzer u_top (
    .clk     (clk),
    .rst     (rst),
    .pix     (pix_if),
    .rpt     (rpt_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 50) $display("[%0t] %s", $realtime, msg);
  endtask

  // Receiver: random stalls, plus one long hold-off on request so the block
  // backs up and stalls its pixel input.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      rpt_if.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served < hold_requests) begin
      rpt_if.ready <= 1'b0;
      hold_served <= hold_served + 1;
      hold_left <= HOLD_CYCLES;
    end else begin
      rpt_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor both channels: feed accepted pixels to the predictor, check reports,
  // and watch for the run getting stuck.
  always @(posedge clk) begin
    if (!rst) begin
      if (pix_if.valid && pix_if.ready) sb.note_pixel(pix_if.red, pix_if.green, pix_if.blue);
      if (rpt_if.valid && rpt_if.ready) begin
        got_report.row_index        = rpt_if.row_index;
        got_report.row_white_count  = rpt_if.row_white_count;
        got_report.row_is_stripe    = rpt_if.row_is_stripe;
        got_report.row_has_wrap     = rpt_if.row_has_wrap;
        got_report.frame_done       = rpt_if.frame_done;
        got_report.total_white      = rpt_if.total_white;
        got_report.stripe_row_count = rpt_if.stripe_row_count;
        got_report.stripe_columns   = rpt_if.stripe_columns;
        got_report.right_wrap_rows  = rpt_if.right_wrap_rows;
        got_report.top_wrap_columns = rpt_if.top_wrap_columns;
        mismatch_msg = sb.check_report(got_report);
        if (mismatch_msg != "") report_mismatch(mismatch_msg);
      end
      if ((pix_if.valid && pix_if.ready) || (rpt_if.valid && rpt_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
        $display("status: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Two-phase APB write; the register takes the value at the access edge.
  task automatic apb_write(reg_addr_t addr, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.set_register(addr, value);
  endtask

  task automatic configure(int w, int h, int wl, int pct, int ml, int jl);
    apb_write(REG_FRAME_WIDTH, w);
    apb_write(REG_FRAME_HEIGHT, h);
    apb_write(REG_WHITE_LEVEL, wl);
    apb_write(REG_STRIPE_PERCENT, pct);
    apb_write(REG_MATCH_LIMIT, ml);
    apb_write(REG_JUMP_LIMIT, jl);
    // let the stripe thresholds settle
    repeat (4) @(posedge clk);
  endtask

  // Offer one pixel and hold it until the beat; valid stays high into the next
  // call unless that call idles first.
  task automatic send_pixel(logic [PIX_W-1:0] px);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      pix_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    pix_if.valid <= 1'b1;
    {pix_if.red, pix_if.green, pix_if.blue} <= px;
    do @(posedge clk); while (!pix_if.ready);
    pixels_sent++;
  endtask

  // Drop valid, drain every predicted report, then wait out the pipeline.
  task automatic settle();
    pix_if.valid <= 1'b0;
    while (sb.expected_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // One whole frame of biased random pixels: blacks, whites, levels near the white
  // threshold, near copies of the row's left pixel and of the column's top pixel.
  task automatic send_frame();
    int               w;
    int               h;
    logic [PIX_W-1:0] left;
    logic [PIX_W-1:0] px;
    w = sb.clamp_size(sb.width_reg, MAX_WIDTH);
    h = sb.clamp_size(sb.height_reg, MAX_HEIGHT);
    left = '0;
    for (int y = 0; y < h; y++) begin
      for (int x = 0; x < w; x++) begin
        case ($urandom_range(0, 9))
          0: px = '0;
          1: px = '1;
          2: px = {3{CH_W'(sb.white_reg + $urandom_range(0, 1) - $urandom_range(0, 1))}};
          3: px = left ^ PIX_W'($urandom_range(0, 3));
          4: px = (y > 0) ? gen_top[x] ^ PIX_W'($urandom_range(0, 3)) : PIX_W'($urandom);
          default: px = PIX_W'($urandom);
        endcase
        if (x == 0) left = px;
        if (y == 0) gen_top[x] = px;
        send_pixel(px);
      end
    end
  endtask

  task automatic set_idling(int phase);
    case (phase % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
      default: begin send_idle_pct = 29; recv_stall_pct = 29; end
    endcase
  endtask

  function automatic int pick_limit();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 120);
  endfunction

  initial begin
    logic [PIX_W-1:0] directed_px[12];
    int               phase;
    int               wl;
    sb = new();
    mismatches = 0; hold_requests = 0; hold_served = 0; hold_left = 0;
    quiet_cycles = 0; pixels_sent = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    pix_if.valid = 1'b0; pix_if.red = '0; pix_if.green = '0; pix_if.blue = '0;
    rpt_if.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed 4x3 frame: white on the threshold and just under it, right edge
    // wraps on the middle and bottom rows, top edge wraps on columns 0, 1 and 3.
    directed_px = '{24'hFFFFFF, 24'hFAFAFA, 24'hF9FAFA, 24'hFFFFFF,
                    24'h102030, 24'h000000, 24'hFFFFFF, 24'h102031,
                    24'hFFFFFE, 24'hFAFAFB, 24'h808080, 24'hFFFFFF};
    configure(4, 3, 250, 50, 10, 50);
    foreach (directed_px[i]) send_pixel(directed_px[i]);
    settle();
    // Two-row frame: the bottom row is also the row below the top.
    configure(2, 2, 0, 0, 1023, 0);
    send_pixel(24'h000000); send_pixel(24'hFFFFFF);
    send_pixel(24'h000001); send_pixel(24'hFFFFFF);
    settle();

    // Long receiver hold-off with the sender pushing short rows.
    configure(2, 6, 128, 40, 20, 30);
    hold_requests++;
    repeat (3) send_frame();
    settle();

    phase = 0;
    while (pixels_sent < RANDOM_PIXELS) begin
      set_idling(phase);
      case ($urandom_range(0, 2))
        0: wl = 0;
        1: wl = 255;
        default: wl = $urandom_range(0, 255);
      endcase
      configure($urandom_range(0, 9), $urandom_range(0, 7), wl, $urandom_range(0, 127),
                pick_limit(), pick_limit());
      repeat ($urandom_range(1, 3)) send_frame();
      settle();
      phase++;
    end

    // Wide and tall frames, extreme limits, and sizes clamped to the minimum.
    set_idling(0);
    configure(40, 2, 255, 100, 0, 1023);
    send_frame();
    settle();
    set_idling(3);
    configure(1, 3, 0, 127, 1023, 0);
    send_frame();
    settle();
    set_idling(0);
    configure(2, 40, 200, 0, 600, 2);
    send_frame();
    settle();
    configure(1, 1, 250, 80, 10, 50);
    send_frame();
    settle();
    set_idling(1);
    configure(0, 0, 128, 100, 766, 765);
    repeat (3) send_frame();
    settle();

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* frame_stripe_and_wrap_analyzer.f */
design/fswa_pkg.sv
design/fswa_if.sv
design/fswa_ram.sv
design/frame_stripe_and_wrap_analyzer.sv
tb/tb_frame_stripe_and_wrap_analyzer.sv
